// ----- sv/ll1er_pkg.sv -----
`timescale 1ns / 1ps

package ll1er_pkg;

  // Symbol stack geometry.
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SYM_W       = 6;
  localparam int MAX_LEN     = 8;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int K_W         = $clog2(MAX_LEN);

  // Symbols are the low six bits of their ASCII code; the end marker is zero.
  localparam logic [SYM_W-1:0] SYM_END = 6'd0;
  localparam logic [SYM_W-1:0] NT_C    = 6'd3;
  localparam logic [SYM_W-1:0] NT_D    = 6'd4;
  localparam logic [SYM_W-1:0] NT_E    = 6'd5;
  localparam logic [SYM_W-1:0] NT_F    = 6'd6;
  localparam logic [SYM_W-1:0] NT_G    = 6'd7;
  localparam logic [SYM_W-1:0] NT_H    = 6'd8;
  localparam logic [SYM_W-1:0] NT_M    = 6'd13;
  localparam logic [SYM_W-1:0] NT_N    = 6'd14;
  localparam logic [SYM_W-1:0] NT_O    = 6'd15;
  localparam logic [SYM_W-1:0] NT_Q    = 6'd17;
  localparam logic [SYM_W-1:0] NT_S    = 6'd19;
  localparam logic [SYM_W-1:0] NT_V    = 6'd22;
  localparam logic [SYM_W-1:0] NT_Z    = 6'd26;
  localparam logic [SYM_W-1:0] T_A     = 6'd33;
  localparam logic [SYM_W-1:0] T_D     = 6'd36;
  localparam logic [SYM_W-1:0] T_E     = 6'd37;
  localparam logic [SYM_W-1:0] T_LPAR  = 6'd40;
  localparam logic [SYM_W-1:0] T_RPAR  = 6'd41;
  localparam logic [SYM_W-1:0] T_STAR  = 6'd42;
  localparam logic [SYM_W-1:0] T_PLUS  = 6'd43;
  localparam logic [SYM_W-1:0] T_MINUS = 6'd45;
  localparam logic [SYM_W-1:0] T_DOT   = 6'd46;
  localparam logic [SYM_W-1:0] T_ZERO  = 6'd48;
  localparam logic [SYM_W-1:0] T_ONE   = 6'd49;
  localparam logic [SYM_W-1:0] T_EIGHT = 6'd56;
  localparam logic [SYM_W-1:0] T_SEMI  = 6'd59;
  localparam logic [SYM_W-1:0] T_EQ    = 6'd61;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] STATUS_PARSING  = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  typedef enum logic [1:0] {
    ACT_MATCH,
    ACT_EXPAND,
    ACT_POP,
    ACT_REJECT
  } act_t;

  // Productions that are expanded. P_TERM replaces the top by the input itself.
  typedef enum logic [3:0] {
    P_TERM, P_S, P_GPAR, P_GN, P_E, P_NV, P_NC, P_QV, P_DC, P_D0, P_FDOT, P_FH, P_HD
  } prod_t;

  typedef struct packed {
    act_t  act;
    prod_t prod;
  } pred_t;

  typedef struct packed {
    logic take_in;
    logic reject;
    logic pop_last;
    logic pop_rd;
    logic load_tos;
    logic expand;
    logic push;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic eot;
    logic rej;
    logic blank;
    logic foreign;
    act_t act;
    logic fits;
    logic len_one;
    logic cnt_one;
    logic k_one;
    logic out_busy;
  } sts_t;

  function automatic logic in_alphabet(input logic [7:0] c);
    logic r;
    case (c) inside
      ["a":"e"], ["0":"8"], "(", ")", "*", "+", "-", ".", ";", "=": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Table entry for nonterminal nt on terminal t.
  function automatic pred_t predict(input logic [SYM_W-1:0] nt, input logic [SYM_W-1:0] t);
    logic  is_v;
    logic  is_c;
    pred_t p;
    is_v = (t >= T_A) && (t <= T_D);
    is_c = (t >= T_ONE) && (t <= T_EIGHT);
    p.act  = ACT_REJECT;
    p.prod = P_TERM;
    case (nt)
      NT_S: begin
        if (is_v) p = '{ACT_EXPAND, P_S};
        else p.act = ACT_POP;
      end
      NT_G: begin
        if (t == T_LPAR) p = '{ACT_EXPAND, P_GPAR};
        else if (is_v || is_c) p = '{ACT_EXPAND, P_GN};
      end
      NT_E: begin
        if (t == T_PLUS || t == T_STAR) p = '{ACT_EXPAND, P_E};
        else p.act = ACT_POP;
      end
      NT_M: begin
        if (t == T_MINUS) p = '{ACT_EXPAND, P_TERM};
        else p.act = ACT_POP;
      end
      NT_N: begin
        if (is_v) p = '{ACT_EXPAND, P_NV};
        else if (is_c) p = '{ACT_EXPAND, P_NC};
      end
      NT_V: begin
        if (is_v) p = '{ACT_EXPAND, P_TERM};
      end
      NT_Q: begin
        if (is_v) p = '{ACT_EXPAND, P_QV};
        else p.act = ACT_POP;
      end
      NT_C: begin
        if (is_c) p = '{ACT_EXPAND, P_TERM};
      end
      NT_D: begin
        if (is_c) p = '{ACT_EXPAND, P_DC};
        else if (t == T_ZERO) p = '{ACT_EXPAND, P_D0};
      end
      NT_F: begin
        if (t == T_DOT) p = '{ACT_EXPAND, P_FDOT};
        else if (is_c || t == T_ZERO) p = '{ACT_EXPAND, P_FH};
        else p.act = ACT_POP;
      end
      NT_H: begin
        if (is_c || t == T_ZERO) p = '{ACT_EXPAND, P_HD};
        else p.act = ACT_POP;
      end
      NT_Z: begin
        if (t == T_PLUS || t == T_MINUS) p = '{ACT_EXPAND, P_TERM};
      end
      NT_O: begin
        if (t == T_PLUS || t == T_STAR) p = '{ACT_EXPAND, P_TERM};
      end
      default: p.act = ACT_REJECT;
    endcase
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] prod_len(input prod_t p);
    logic [LEN_W-1:0] n;
    case (p)
      P_S, P_GPAR:                n = LEN_W'(8);
      P_E:                        n = LEN_W'(4);
      P_FDOT:                     n = LEN_W'(5);
      P_NV, P_NC, P_DC, P_D0:     n = LEN_W'(2);
      default:                    n = LEN_W'(1);
    endcase
    return n;
  endfunction

  // Symbol at position idx of the right-hand side; position 0 ends up on top.
  function automatic logic [SYM_W-1:0] prod_sym(input prod_t p, input logic [K_W-1:0] idx,
                                                input logic [SYM_W-1:0] t);
    logic [MAX_LEN*SYM_W-1:0] s;
    s = '0;
    case (p)
      P_S:    s = {NT_S, T_SEMI, NT_E, NT_G, NT_M, T_EQ, NT_Q, NT_V};
      P_GPAR: s = {T_RPAR, NT_E, NT_G, NT_M, NT_O, NT_G, NT_M, T_LPAR};
      P_GN:   s[5:0] = NT_N;
      P_E:    s[23:0] = {NT_E, NT_G, NT_M, NT_O};
      P_NV:   s[11:0] = {NT_Q, NT_V};
      P_NC:   s[11:0] = {NT_F, NT_C};
      P_QV:   s[5:0] = NT_V;
      P_DC:   s[11:0] = {NT_H, NT_C};
      P_D0:   s[11:0] = {NT_H, T_ZERO};
      P_FDOT: s[29:0] = {NT_D, NT_Z, T_E, NT_D, T_DOT};
      P_FH:   s[5:0] = NT_H;
      P_HD:   s[5:0] = NT_D;
      default: s[5:0] = t;
    endcase
    return s[idx*SYM_W +: SYM_W];
  endfunction

endpackage

// ----- sv/ll1er_ctrl.sv -----
`timescale 1ns / 1ps

module ll1er_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ll1er_pkg::sts_t  sts,
  output ll1er_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_CHECK     = 6'b000010,
    ST_EVAL      = 6'b000100,
    ST_PUSH      = 6'b001000,
    ST_LOAD_EVAL = 6'b010000,
    ST_LOAD_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   done;
  logic   done_next;

  assign in_stall = (state != ST_IDLE) || done;

  always_comb begin
    state_next = state;
    done_next  = done;
    cmd        = '0;
    if (done) begin
      // The result waits here until the output register is free.
      if (!sts.out_busy) begin
        cmd.out_load = 1'b1;
        done_next    = 1'b0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd.take_in = 1'b1;
            state_next  = ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
          if (sts.eot) begin
            if (!sts.rej) begin
              state_next = ST_EVAL;
              done_next  = 1'b0;
            end
          end else if (!sts.rej && !sts.blank) begin
            if (sts.foreign) begin
              cmd.reject = 1'b1;
            end else begin
              state_next = ST_EVAL;
              done_next  = 1'b0;
            end
          end
        end
        ST_EVAL: begin
          case (sts.act)
            ll1er_pkg::ACT_MATCH: begin
              if (sts.cnt_one) begin
                cmd.pop_last = 1'b1;
                state_next   = ST_IDLE;
                done_next    = 1'b1;
              end else begin
                cmd.pop_rd = 1'b1;
                state_next = ST_LOAD_DONE;
              end
            end
            ll1er_pkg::ACT_POP: begin
              cmd.pop_rd = 1'b1;
              state_next = ST_LOAD_EVAL;
            end
            ll1er_pkg::ACT_EXPAND: begin
              if (!sts.fits) begin
                cmd.reject = 1'b1;
                state_next = ST_IDLE;
                done_next  = 1'b1;
              end else begin
                cmd.expand = 1'b1;
                if (!sts.len_one) state_next = ST_PUSH;
              end
            end
            default: begin
              cmd.reject = 1'b1;
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end
          endcase
        end
        ST_PUSH: begin
          cmd.push = 1'b1;
          if (sts.k_one) state_next = ST_EVAL;
        end
        ST_LOAD_EVAL: begin
          cmd.load_tos = 1'b1;
          state_next   = ST_EVAL;
        end
        ST_LOAD_DONE: begin
          cmd.load_tos = 1'b1;
          state_next   = ST_IDLE;
          done_next    = 1'b1;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// ----- sv/ll1er_datapath.sv -----
`timescale 1ns / 1ps

module ll1er_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       character,
  input  logic             end_of_text,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  input  ll1er_pkg::cmd_t  cmd,
  output ll1er_pkg::sts_t  sts
);

  logic [7:0]                       chr;
  logic                             eot;
  logic                             rej;
  logic [ll1er_pkg::SYM_W-1:0]      tos;
  logic [ll1er_pkg::CNT_W-1:0]      cnt;
  logic [ll1er_pkg::K_W-1:0]        k;
  ll1er_pkg::prod_t                 prod;
  logic [ll1er_pkg::SYM_W-1:0]      rd;
  logic [ll1er_pkg::SYM_W-1:0]      mem [ll1er_pkg::STACK_DEPTH];

  logic [ll1er_pkg::SYM_W-1:0]      t;
  ll1er_pkg::pred_t                 pred;
  logic [ll1er_pkg::LEN_W-1:0]      len;
  logic [ll1er_pkg::CNT_W:0]        need;
  logic [ll1er_pkg::ADDR_W-1:0]     wr_addr;
  logic [ll1er_pkg::ADDR_W-1:0]     rd_addr;
  logic                             fin_end;

  assign t       = eot ? ll1er_pkg::SYM_END : chr[ll1er_pkg::SYM_W-1:0];
  assign pred    = (tos == t) ? '{ll1er_pkg::ACT_MATCH, ll1er_pkg::P_TERM}
                              : ll1er_pkg::predict(tos, t);
  assign len     = ll1er_pkg::prod_len(pred.prod);
  assign need    = (ll1er_pkg::CNT_W+1)'(cnt) + (ll1er_pkg::CNT_W+1)'(len)
                   - (ll1er_pkg::CNT_W+1)'(1);
  assign wr_addr = ll1er_pkg::ADDR_W'(cnt - ll1er_pkg::CNT_W'(1));
  assign rd_addr = ll1er_pkg::ADDR_W'(cnt - ll1er_pkg::CNT_W'(2));
  assign fin_end = cmd.out_load && eot;

  assign sts.eot      = eot;
  assign sts.rej      = rej;
  assign sts.blank    = (chr == ll1er_pkg::CH_SPACE) || (chr == ll1er_pkg::CH_TAB);
  assign sts.foreign  = !ll1er_pkg::in_alphabet(chr);
  assign sts.act      = pred.act;
  assign sts.fits     = need <= (ll1er_pkg::CNT_W+1)'(ll1er_pkg::STACK_DEPTH);
  assign sts.len_one  = len == ll1er_pkg::LEN_W'(1);
  assign sts.cnt_one  = cnt == ll1er_pkg::CNT_W'(1);
  assign sts.k_one    = k == ll1er_pkg::K_W'(1);
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      chr <= character;
      eot <= end_of_text;
    end
    if (cmd.expand) prod <= pred.prod;
    if (cmd.expand) begin
      k <= ll1er_pkg::K_W'(len - ll1er_pkg::LEN_W'(1));
    end else if (cmd.push) begin
      k <= k - ll1er_pkg::K_W'(1);
    end
    if (cmd.push) mem[wr_addr] <= ll1er_pkg::prod_sym(prod, k, t);
    // The bottom entry is always the end marker and is never written.
    if (cmd.pop_rd) rd <= (rd_addr == '0) ? ll1er_pkg::SYM_END : mem[rd_addr];
    if (cmd.out_load) begin
      status <= !eot           ? ll1er_pkg::STATUS_PARSING :
                (!rej && cnt == '0) ? ll1er_pkg::STATUS_ACCEPTED :
                                  ll1er_pkg::STATUS_REJECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || fin_end) begin
      tos <= ll1er_pkg::NT_S;
      cnt <= ll1er_pkg::CNT_W'(2);
      rej <= 1'b0;
    end else begin
      if (cmd.reject) rej <= 1'b1;
      if (cmd.pop_last) cnt <= '0;
      if (cmd.pop_rd) cnt <= cnt - ll1er_pkg::CNT_W'(1);
      if (cmd.load_tos) tos <= rd;
      if (cmd.expand && len == ll1er_pkg::LEN_W'(1)) begin
        tos <= ll1er_pkg::prod_sym(pred.prod, '0, t);
      end
      if (cmd.push) begin
        cnt <= cnt + ll1er_pkg::CNT_W'(1);
        if (k == ll1er_pkg::K_W'(1)) tos <= ll1er_pkg::prod_sym(prod, '0, t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= ll1er_pkg::CNT_W'(ll1er_pkg::STACK_DEPTH))
    else $error("stack count above depth");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    fin_end |=> (cnt == ll1er_pkg::CNT_W'(2)) && (tos == ll1er_pkg::NT_S) && !rej)
    else $error("stack not restored after end item");
  a_push_k: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> k != '0)
    else $error("push with no symbol left");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwrote a waiting result");
`endif

endmodule

// ----- sv/ll1_expression_recognizer.sv -----
`timescale 1ns / 1ps

// LL(1) recognizer for assignment statements such as "a=-b*(c+1.5e-2);".
// Characters arrive one item at a time on the input channel; spaces and tabs
// are skipped, and any character outside the grammar's alphabet rejects the
// string. Every character item returns one result item with status 0. An item
// with end_of_text set drives the end marker, returns status 1 (accepted) or
// 2 (rejected), and returns the block to its reset state. The symbol stack
// holds STACK_DEPTH entries in a memory, with the top symbol in a register;
// an expansion that would overflow it rejects. An item is accepted, checked
// and has its result loaded, with its stack work in between: an expansion
// whose right-hand side holds one symbol loads it into the top register,
// and a longer one is pushed through the single write port of the stack
// memory, one symbol a cycle, with the first symbol going into the top
// register on the last write. Each pop, including the one that consumes the
// character, goes through a registered stack read, unless it empties the
// stack. Skipped blanks and items after a rejection do no stack work.
// The result register lets the next item be accepted while a result waits.

module ll1_expression_recognizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] character,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status
);

  ll1er_pkg::cmd_t cmd;
  ll1er_pkg::sts_t sts;

  // Sequencer: walks one item through check, expansions, pops and result.
  ll1er_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stack, parse table lookup and result register.
  ll1er_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .character   (character),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ----- tb/tb_ll1_expression_recognizer.sv -----
`timescale 1ns / 1ps

// Every character and end-of-text item sent to the recognizer returns one
// status item. The predictor below keeps its own symbol stack, worked from
// the grammar rules, and the scoreboard compares each status item in order.

class status_scoreboard;
  logic [1:0] pending[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  function void note_item(logic [1:0] st);
    pending = {pending, st};
  endfunction

  function void check_status(logic [1:0] got);
    logic [1:0] want;
    if (pending.size() == 0) begin
      $error("status: unexpected item, actual %0d", got);
      errors++;
    end else begin
      want = pending.pop_front();
      if (want !== got) begin
        $error("status: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction
endclass

module tb_ll1_expression_recognizer;

  localparam int DEPTH = ll1er_pkg::STACK_DEPTH;
  localparam byte ENDM = "$";

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] character;
  logic       end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;

  ll1_expression_recognizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .character(character), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_stall(out_stall), .status(status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  status_scoreboard sb;

  // The predictor's own copy of the parser state. Symbols are held as their
  // ASCII codes; nonterminals are the capital letters.
  byte sym_stack[DEPTH];
  int  depth_used;
  bit  string_rejected;
  bit  hold_on;
  event hold_start;

  function automatic void parser_clear();
    sym_stack[0] = ENDM;
    sym_stack[1] = "S";
    depth_used = 2;
    string_rejected = 1'b0;
  endfunction

  // Right-hand sides of each rule in priority order; an empty string is the
  // empty alternative.
  function automatic void rule_alts(byte nt, output string alts[$]);
    alts = {};
    case (nt)
      "S": alts = {"VQ=MGE;S", ""};
      "G": alts = {"(MGOMGE)", "N"};
      "E": alts = {"OMGE", ""};
      "M": alts = {"-", ""};
      "N": alts = {"VQ", "CF"};
      "V": alts = {"a", "b", "c", "d"};
      "Q": alts = {"V", ""};
      "C": alts = {"1", "2", "3", "4", "5", "6", "7", "8"};
      "D": alts = {"CH", "0H"};
      "F": alts = {".DeZD", "H"};
      "H": alts = {"D", ""};
      "Z": alts = {"+", "-"};
      "O": alts = {"+", "*"};
      default: alts = {};
    endcase
  endfunction

  function automatic bit is_nonterminal(byte c);
    return c >= "A" && c <= "Z";
  endfunction

  // Picks the alternative whose leading symbol, followed through leading
  // nonterminals, is the terminal t. The flag notes a reachable empty one.
  function automatic bit pick_alt(byte t, byte nt, inout bit saw_empty,
                                  input int lvl, output string chosen);
    string alts[$];
    string sub;
    byte   first;
    bit    hit;
    chosen = "";
    if (lvl > 16) return 1'b0;
    rule_alts(nt, alts);
    foreach (alts[i]) begin
      if (alts[i].len() == 0) begin
        saw_empty = 1'b1;
        continue;
      end
      first = alts[i][0];
      if (is_nonterminal(first)) begin
        hit = pick_alt(t, first, saw_empty, lvl + 1, sub);
        if (hit) begin
          chosen = alts[i];
          return 1'b1;
        end
      end
      if (first == t) begin
        chosen = alts[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit char_known(byte c);
    string alphabet;
    alphabet = " \tabcde012345678()*+-.;=";
    foreach (alphabet[i]) if (alphabet[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Pushes one terminal through the stack until it is matched or rejected.
  function automatic void feed_terminal(byte t);
    byte   top;
    bit    saw_empty;
    string rhs;
    for (int guard = 0; guard < 4 * DEPTH + 64; guard++) begin
      if (depth_used == 0) begin
        string_rejected = 1'b1;
        return;
      end
      top = sym_stack[depth_used - 1];
      if (top == t) begin
        depth_used--;
        return;
      end
      saw_empty = 1'b0;
      if (pick_alt(t, top, saw_empty, 0, rhs)) begin
        if (depth_used - 1 + rhs.len() > DEPTH) begin
          string_rejected = 1'b1;
          return;
        end
        depth_used--;
        for (int j = rhs.len() - 1; j >= 0; j--) begin
          sym_stack[depth_used] = rhs[j];
          depth_used++;
        end
        continue;
      end
      if (saw_empty) begin
        depth_used--;
        continue;
      end
      string_rejected = 1'b1;
      return;
    end
    string_rejected = 1'b1;
  endfunction

  // Works out the status for one accepted input item.
  function automatic logic [1:0] predict_status(logic [7:0] ch, logic eot);
    bit ok;
    if (eot) begin
      if (!string_rejected) feed_terminal(ENDM);
      ok = !string_rejected && depth_used == 0;
      parser_clear();
      return ok ? ll1er_pkg::STATUS_ACCEPTED : ll1er_pkg::STATUS_REJECTED;
    end
    if (string_rejected || ch == ll1er_pkg::CH_SPACE || ch == ll1er_pkg::CH_TAB)
      return ll1er_pkg::STATUS_PARSING;
    if (!char_known(ch)) begin
      string_rejected = 1'b1;
      return ll1er_pkg::STATUS_PARSING;
    end
    feed_terminal(ch);
    return ll1er_pkg::STATUS_PARSING;
  endfunction

  // Gaps are mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and holds it until the block takes it.
  task automatic send_item(logic [7:0] ch, logic eot);
    in_valid <= 1'b1;
    character <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(predict_status(ch, eot));
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      character <= 8'($urandom);
      end_of_text <= $urandom_range(0, 1);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_text(string s, bit with_gaps);
    foreach (s[i]) begin
      send_item(s[i], 1'b0);
      if (with_gaps) idle_input(gap_len());
    end
    send_item(8'($urandom), 1'b1);
    if (with_gaps) idle_input(gap_len());
  endtask

  // Builds a pieces of a well-formed statement with random content.
  function automatic string rand_var();
    string v;
    v = "a";
    v[0] = "a" + $urandom_range(0, 3);
    if ($urandom_range(0, 1)) begin
      v = {v, "a"};
      v[1] = "a" + $urandom_range(0, 3);
    end
    return v;
  endfunction

  function automatic string rand_digits();
    string d;
    d = "1";
    d[0] = "1" + $urandom_range(0, 7);
    repeat ($urandom_range(0, 3)) begin
      d = {d, "0"};
      d[d.len() - 1] = "0" + $urandom_range(0, 8);
    end
    return d;
  endfunction

  function automatic string rand_number();
    string n;
    n = rand_digits();
    if ($urandom_range(0, 2) == 0) begin
      n = {n, ".", ($urandom_range(0, 1) ? "0" : rand_digits()), "e",
           ($urandom_range(0, 1) ? "+" : "-"), rand_digits()};
    end
    return n;
  endfunction

  function automatic string rand_operand(int lvl);
    string s;
    s = ($urandom_range(0, 3) == 0) ? "-" : "";
    if (lvl < 3 && $urandom_range(0, 4) == 0)
      return {s, "(", rand_operand(lvl + 1), ($urandom_range(0, 1) ? "+" : "*"),
              rand_operand(lvl + 1), ")"};
    return {s, ($urandom_range(0, 1) ? rand_var() : rand_number())};
  endfunction

  function automatic string rand_statement();
    string s;
    s = {rand_var(), "=", rand_operand(0)};
    repeat ($urandom_range(0, 2))
      s = {s, ($urandom_range(0, 1) ? "+" : "*"), rand_operand(0)};
    return {s, ";"};
  endfunction

  // Damages a text: a changed, dropped or foreign character, or a blank.
  function automatic string mangle(string s);
    int    pos;
    string pool;
    pool = "abcde012345678()*+-.;= \t";
    if (s.len() == 0) return s;
    pos = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 3))
      0: s[pos] = pool[$urandom_range(0, pool.len() - 1)];
      1: s = {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
      2: s[pos] = 8'($urandom);
      default: s = {s.substr(0, pos - 1), " ", s.substr(pos, s.len() - 1)};
    endcase
    return s;
  endfunction

  // Drains the expected statuses: the sender stands still meanwhile.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Long receiver hold-off, counted here once it is asked for.
  initial begin
    hold_on = 1'b0;
    @(hold_start);
    hold_on <= 1'b1;
    repeat (200) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver: random stalls, plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_status(status);
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 19) != 0 || 1'b1)
                     ? ($urandom_range(0, 9) < 9 ? ($urandom_range(0, 2) == 0) : 1'b1)
                     : 1'b0;
      end
    end
  end

  initial begin
    int    sent;
    string s;
    sb = new();
    parser_clear();
    rst = 1'b1;
    in_valid = 1'b0;
    character = 8'h00;
    end_of_text = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a good statement, blanks, an empty string, extremes of the
    // character, a foreign character, a mismatch and characters after it.
    send_text("ab=-(c+1.0e-8)*d;", 1'b0);
    send_text(" \t", 1'b0);
    s = "a=b;";
    s = {s, "X"};
    s[4] = 8'hff;
    send_text(s, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'($urandom), 1'b1);
    send_text("a==b;", 1'b0);
    send_text("=", 1'b0);
    send_text("e", 1'b0);

    // Deep nesting overflows the stack.
    s = "a=";
    repeat (12) s = {s, "("};
    send_text({s, "b"}, 1'b0);
    wait_drained();

    // Long hold-off at the receiver while items keep coming in.
    -> hold_start;
    send_text(rand_statement(), 1'b0);
    send_text(rand_statement(), 1'b0);
    wait_drained();

    sent = 0;
    while (sent < 420) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: s = rand_statement();
        6: s = {rand_statement(), rand_statement()};
        7, 8: s = mangle(rand_statement());
        default: begin
          s = "";
          repeat ($urandom_range(0, 6)) s = {s, " "};
          foreach (s[i]) s[i] = 8'($urandom);
        end
      endcase
      send_text(s, $urandom_range(0, 3) != 0);
      sent += s.len() + 1;
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
